// ----- hdl/ssbp_pkg.sv -----
// shared constants and types for the sphere screen bounds projector
package ssbp_pkg;

    // fixed point format
    localparam int FRAC_BITS_DEF = 16;

    // configuration register reset values
    localparam logic [30:0] NEAR_RST    = 31'd6554;
    localparam logic [30:0] SCALE_X_RST = 31'd68107;
    localparam logic [30:0] SCALE_Y_RST = 31'd113512;

    // configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_NEAR    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SCALE_X = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SCALE_Y = 2'd2;

    // pipeline depths
    localparam int SQRT_STEPS = 32;
    localparam int DIV_STEPS  = 40;
    localparam int DIV_LAT    = DIV_STEPS + 4;
    localparam int AXIS_FRONT = 3;
    localparam int AXIS_MID   = 3;
    localparam int AXIS_LAT   = AXIS_FRONT + SQRT_STEPS + AXIS_MID + DIV_LAT;

    // per axis result
    typedef struct packed {
        logic               ok;
        logic signed [31:0] lo;
        logic signed [31:0] hi;
    } t_axis_res;

endpackage

// ----- hdl/ssbp_div.sv -----
// pipelined scaled bound: sign * floor(mag * scale / (2 * den)) + half, saturated
module ssbp_div import ssbp_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_neg,
    input  logic [63:0]        i_mag,
    input  logic [63:0]        i_den,
    input  logic [30:0]        i_scale,
    output logic signed [31:0] o_bound
);

    localparam int QW = DIV_STEPS;
    localparam int BW = QW + 2;
    localparam logic signed [BW-1:0] HALF   = BW'(1) << (FRAC_BITS - 1);
    localparam logic signed [BW-1:0] MAX_32 = BW'(32'sh7FFF_FFFF);
    localparam logic signed [BW-1:0] MIN_32 = -(BW'(1) << 31);

    // partial products
    logic [62:0] n_pl, n_ph;
    logic [62:0] r_m1_pl, r_m1_ph;
    logic [63:0] r_m1_den;
    logic        r_m1_neg;

    assign n_pl = i_mag[31:0] * i_scale;
    assign n_ph = i_mag[63:32] * i_scale;

    always_ff @(posedge i_clk) begin
        r_m1_pl  <= n_pl;
        r_m1_ph  <= n_ph;
        r_m1_den <= i_den;
        r_m1_neg <= i_neg;
    end

    // full product
    logic [94:0] r_m2_num;
    logic [63:0] r_m2_den;
    logic        r_m2_neg;

    always_ff @(posedge i_clk) begin
        r_m2_num <= {32'd0, r_m1_pl} + {r_m1_ph, 32'd0};
        r_m2_den <= r_m1_den;
        r_m2_neg <= r_m1_neg;
    end

    // quotient cap check and initial remainder
    logic [63:0]   r_m3_rem;
    logic [QW-1:0] r_m3_lo;
    logic [63:0]   r_m3_den;
    logic          r_m3_sat;
    logic          r_m3_neg;

    always_ff @(posedge i_clk) begin
        r_m3_sat <= {9'd0, r_m2_num[94:QW]} >= r_m2_den;
        r_m3_rem <= {9'd0, r_m2_num[94:QW]};
        r_m3_lo  <= r_m2_num[QW-1:0];
        r_m3_den <= r_m2_den;
        r_m3_neg <= r_m2_neg;
    end

    // one quotient bit per stage
    logic [63:0]   r_rem [DIV_STEPS];
    logic [QW-1:0] r_lo  [DIV_STEPS];
    logic [QW-1:0] r_q   [DIV_STEPS];
    logic [63:0]   r_den [DIV_STEPS];
    logic          r_sat [DIV_STEPS];
    logic          r_neg [DIV_STEPS];

    for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
        logic [63:0]   w_rem;
        logic [QW-1:0] w_lo;
        logic [QW-1:0] w_q;
        logic [63:0]   w_den;
        logic          w_sat;
        logic          w_neg;
        logic [64:0]   w_shift;
        logic          w_ge;

        if (k == 0) begin : g_first
            assign w_rem = r_m3_rem;
            assign w_lo  = r_m3_lo;
            assign w_q   = '0;
            assign w_den = r_m3_den;
            assign w_sat = r_m3_sat;
            assign w_neg = r_m3_neg;
        end else begin : g_next
            assign w_rem = r_rem[k-1];
            assign w_lo  = r_lo[k-1];
            assign w_q   = r_q[k-1];
            assign w_den = r_den[k-1];
            assign w_sat = r_sat[k-1];
            assign w_neg = r_neg[k-1];
        end

        assign w_shift = {w_rem, w_lo[QW-1]};
        assign w_ge    = w_shift >= {1'b0, w_den};

        always_ff @(posedge i_clk) begin
            r_rem[k] <= w_ge ? 64'(w_shift - {1'b0, w_den}) : w_shift[63:0];
            r_lo[k]  <= {w_lo[QW-2:0], 1'b0};
            r_q[k]   <= {w_q[QW-2:0], w_ge};
            r_den[k] <= w_den;
            r_sat[k] <= w_sat;
            r_neg[k] <= w_neg;
        end
    end

    // halve, apply sign, add half, saturate
    logic [QW-1:0]        w_h;
    logic signed [BW-1:0] w_sv;
    logic signed [BW-1:0] w_sum;

    assign w_h   = r_sat[DIV_STEPS-1] ? (QW'(1) << (QW - 1))
                                      : {1'b0, r_q[DIV_STEPS-1][QW-1:1]};
    assign w_sv  = r_neg[DIV_STEPS-1] ? -$signed({2'b00, w_h}) : $signed({2'b00, w_h});
    assign w_sum = w_sv + HALF;

    always_ff @(posedge i_clk) begin
        if (w_sum > MAX_32) begin
            o_bound <= 32'sh7FFF_FFFF;
        end else if (w_sum < MIN_32) begin
            o_bound <= 32'sh8000_0000;
        end else begin
            o_bound <= w_sum[31:0];
        end
    end

endmodule

// ----- hdl/ssbp_axis.sv -----
// one axis: tangent distance, slope numerators and denominators, two bounds
module ssbp_axis import ssbp_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF,
    parameter bit FLIP      = 1'b0
) (
    input  logic               i_clk,
    input  logic signed [31:0] i_center,
    input  logic [30:0]        i_depth,
    input  logic [30:0]        i_radius,
    input  logic [30:0]        i_scale,
    output t_axis_res          o_res
);

    typedef struct packed {
        logic        cn;
        logic [31:0] cm;
        logic [30:0] z;
        logic [30:0] r;
    } t_sb;

    // sign and magnitude of the center
    t_sb r_a1;

    always_ff @(posedge i_clk) begin
        r_a1.cn <= i_center[31];
        r_a1.cm <= i_center[31] ? 32'(-i_center) : 32'(i_center);
        r_a1.z  <= i_depth;
        r_a1.r  <= i_radius;
    end

    // squares
    logic [63:0] r_a2_cm2;
    logic [61:0] r_a2_z2, r_a2_r2;
    t_sb         r_a2;

    always_ff @(posedge i_clk) begin
        r_a2_cm2 <= r_a1.cm * r_a1.cm;
        r_a2_z2  <= r_a1.z * r_a1.z;
        r_a2_r2  <= r_a1.r * r_a1.r;
        r_a2     <= r_a1;
    end

    // radicand c^2 + z^2 - r^2
    logic [63:0] r_a3_rad;
    t_sb         r_a3;

    always_ff @(posedge i_clk) begin
        r_a3_rad <= r_a2_cm2 + {2'b00, r_a2_z2} - {2'b00, r_a2_r2};
        r_a3     <= r_a2;
    end

    // digit by digit square root, one result bit per stage
    logic [63:0] r_sq_rem [SQRT_STEPS];
    logic [63:0] r_sq_res [SQRT_STEPS];
    t_sb         r_sq_sb  [SQRT_STEPS];

    for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
        localparam logic [63:0] BIT = 64'(1) << (2 * (SQRT_STEPS - 1 - k));
        logic [63:0] w_rem;
        logic [63:0] w_res;
        t_sb         w_sb;
        logic [64:0] w_trial;
        logic        w_ge;

        if (k == 0) begin : g_first
            assign w_rem = r_a3_rad;
            assign w_res = '0;
            assign w_sb  = r_a3;
        end else begin : g_next
            assign w_rem = r_sq_rem[k-1];
            assign w_res = r_sq_res[k-1];
            assign w_sb  = r_sq_sb[k-1];
        end

        assign w_trial = {1'b0, w_res} + {1'b0, BIT};
        assign w_ge    = {1'b0, w_rem} >= w_trial;

        always_ff @(posedge i_clk) begin
            r_sq_rem[k] <= w_ge ? 64'(w_rem - w_trial[63:0]) : w_rem;
            r_sq_res[k] <= w_ge ? (w_res >> 1) + BIT : w_res >> 1;
            r_sq_sb[k]  <= w_sb;
        end
    end

    // cross products
    logic [31:0] w_v;
    t_sb         w_sq_sb;
    logic [63:0] r_p1_vc;
    logic [61:0] r_p1_zr;
    logic [62:0] r_p1_vz, r_p1_cr;
    logic        r_p1_cn;

    assign w_v     = r_sq_res[SQRT_STEPS-1][31:0];
    assign w_sq_sb = r_sq_sb[SQRT_STEPS-1];

    always_ff @(posedge i_clk) begin
        r_p1_vc <= w_v * w_sq_sb.cm;
        r_p1_zr <= w_sq_sb.z * w_sq_sb.r;
        r_p1_vz <= w_v * w_sq_sb.z;
        r_p1_cr <= w_sq_sb.cm * w_sq_sb.r;
        r_p1_cn <= w_sq_sb.cn;
    end

    // slope numerators and denominators
    logic signed [65:0] w_svc, w_scr, w_zr, w_vz;
    logic signed [65:0] r_p2_n1, r_p2_n2, r_p2_d1, r_p2_d2;

    assign w_svc = r_p1_cn ? -$signed({2'b00, r_p1_vc}) : $signed({2'b00, r_p1_vc});
    assign w_scr = r_p1_cn ? -$signed({3'b000, r_p1_cr}) : $signed({3'b000, r_p1_cr});
    assign w_zr  = $signed({4'b0000, r_p1_zr});
    assign w_vz  = $signed({3'b000, r_p1_vz});

    always_ff @(posedge i_clk) begin
        r_p2_n1 <= w_svc - w_zr;
        r_p2_n2 <= w_svc + w_zr;
        r_p2_d1 <= w_vz + w_scr;
        r_p2_d2 <= w_vz - w_scr;
    end

    // sign and magnitude, denominator check
    logic signed [65:0] w_abs1, w_abs2;
    logic        r_p3_neg1, r_p3_neg2, r_p3_ok;
    logic [63:0] r_p3_mag1, r_p3_mag2, r_p3_den1, r_p3_den2;

    assign w_abs1 = r_p2_n1[65] ? -r_p2_n1 : r_p2_n1;
    assign w_abs2 = r_p2_n2[65] ? -r_p2_n2 : r_p2_n2;

    always_ff @(posedge i_clk) begin
        r_p3_neg1 <= r_p2_n1[65] ^ FLIP;
        r_p3_neg2 <= r_p2_n2[65] ^ FLIP;
        r_p3_mag1 <= w_abs1[63:0];
        r_p3_mag2 <= w_abs2[63:0];
        r_p3_den1 <= r_p2_d1[63:0];
        r_p3_den2 <= r_p2_d2[63:0];
        r_p3_ok   <= !r_p2_d1[65] && (r_p2_d1 != '0) && !r_p2_d2[65] && (r_p2_d2 != '0);
    end

    // the two bounds
    logic signed [31:0] w_lo, w_hi;

    ssbp_div #(.FRAC_BITS(FRAC_BITS)) u_div_lo (
        .i_clk   (i_clk),
        .i_neg   (r_p3_neg1),
        .i_mag   (r_p3_mag1),
        .i_den   (r_p3_den1),
        .i_scale (i_scale),
        .o_bound (w_lo)
    );

    ssbp_div #(.FRAC_BITS(FRAC_BITS)) u_div_hi (
        .i_clk   (i_clk),
        .i_neg   (r_p3_neg2),
        .i_mag   (r_p3_mag2),
        .i_den   (r_p3_den2),
        .i_scale (i_scale),
        .o_bound (w_hi)
    );

    // denominator check rides along with the dividers
    logic r_ok_d [DIV_LAT];

    always_ff @(posedge i_clk) begin
        r_ok_d[0] <= r_p3_ok;
        for (int i = 1; i < DIV_LAT; i++) begin
            r_ok_d[i] <= r_ok_d[i-1];
        end
    end

    assign o_res.ok = r_ok_d[DIV_LAT-1];
    assign o_res.lo = w_lo;
    assign o_res.hi = w_hi;

endmodule

// ----- hdl/sphere_screen_bounds_projector.sv -----
// top level: perspective projected sphere bounding rectangle in uv space
//
// one sphere (view space center, forward depth, radius) is taken per request
// and one uv rectangle comes out per request, in order. busy is always low,
// so a request may be issued in every clock cycle. the result for a request
// accepted at clock edge n is presented with o_valid high after it passes the
// input register (loaded at edge n), 3 front stages, a 32 stage square
// root, 3 product/sum stages, a 44 stage scaled divider and one output
// register. the divider is a 40 step restoring divider and the square root
// is computed digit by digit in 32 steps, one result bit per step. o_valid
// lasts exactly one cycle and cannot be held off, so the receiver must take
// it then. configuration registers (near plane, x and y projection scale)
// are always ready and should only be written while no request is in flight.
// a sphere closer than radius plus near plane, or one whose tangent
// denominators are not positive, reports o_visible low and all bounds zero.
module sphere_screen_bounds_projector import ssbp_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // request channel
    input  logic                 start,
    output logic                 busy,
    input  logic signed [31:0]   i_center_x,
    input  logic signed [31:0]   i_center_y,
    input  logic signed [31:0]   i_center_z,
    input  logic [30:0]          i_radius,
    // result channel
    output logic                 o_valid,
    output logic                 o_visible,
    output logic signed [31:0]   o_u_min,
    output logic signed [31:0]   o_v_min,
    output logic signed [31:0]   o_u_max,
    output logic signed [31:0]   o_v_max,
    // configuration write channel
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [30:0]          i_cfg_data
);

    // never stalls
    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;

    // configuration registers
    logic [30:0] r_near_plane, r_scale_x, r_scale_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_near_plane <= NEAR_RST;
            r_scale_x    <= SCALE_X_RST;
            r_scale_y    <= SCALE_Y_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_NEAR:    r_near_plane <= i_cfg_data;
                CFG_SCALE_X: r_scale_x    <= i_cfg_data;
                CFG_SCALE_Y: r_scale_y    <= i_cfg_data;
                default:     ;
            endcase
        end
    end

    // input register
    logic               r_vld;
    logic signed [31:0] r_cx, r_cy, r_cz;
    logic [30:0]        r_rad;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= start && !busy;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cx  <= i_center_x;
        r_cy  <= i_center_y;
        r_cz  <= i_center_z;
        r_rad <= i_radius;
    end

    // near plane test: depth >= radius + near
    logic w_near_ok;

    assign w_near_ok = $signed({{2{r_cz[31]}}, r_cz})
                       >= $signed({2'b00, 32'(r_rad) + 32'(r_near_plane)});

    // both axes in parallel, y with its sign flipped for uv
    t_axis_res w_ax, w_ay;

    ssbp_axis #(.FRAC_BITS(FRAC_BITS), .FLIP(1'b0)) u_axis_x (
        .i_clk    (i_clk),
        .i_center (r_cx),
        .i_depth  (r_cz[30:0]),
        .i_radius (r_rad),
        .i_scale  (r_scale_x),
        .o_res    (w_ax)
    );

    ssbp_axis #(.FRAC_BITS(FRAC_BITS), .FLIP(1'b1)) u_axis_y (
        .i_clk    (i_clk),
        .i_center (r_cy),
        .i_depth  (r_cz[30:0]),
        .i_radius (r_rad),
        .i_scale  (r_scale_y),
        .o_res    (w_ay)
    );

    // valid and near test follow the axis pipelines
    logic r_vld_d  [AXIS_LAT];
    logic r_near_d [AXIS_LAT];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < AXIS_LAT; i++) begin
                r_vld_d[i] <= 1'b0;
            end
        end else begin
            r_vld_d[0] <= r_vld;
            for (int i = 1; i < AXIS_LAT; i++) begin
                r_vld_d[i] <= r_vld_d[i-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_near_d[0] <= w_near_ok;
        for (int i = 1; i < AXIS_LAT; i++) begin
            r_near_d[i] <= r_near_d[i-1];
        end
    end

    // output register; v_min is the top bound, v_max the bottom one
    logic w_vis;

    assign w_vis = r_near_d[AXIS_LAT-1] && w_ax.ok && w_ay.ok;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= r_vld_d[AXIS_LAT-1];
        end
    end

    always_ff @(posedge i_clk) begin
        o_visible <= w_vis;
        o_u_min   <= w_vis ? w_ax.lo : '0;
        o_u_max   <= w_vis ? w_ax.hi : '0;
        o_v_min   <= w_vis ? w_ay.hi : '0;
        o_v_max   <= w_vis ? w_ay.lo : '0;
    end

    // checks
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |-> ##(AXIS_LAT + 2) o_valid)
        else $error("result missing after fixed latency");

    a_hidden_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_visible |-> (o_u_min == 0) && (o_u_max == 0)
                                  && (o_v_min == 0) && (o_v_max == 0))
        else $error("hidden sphere with nonzero bounds");

    a_cfg_near: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_valid && o_cfg_ready && (i_cfg_index == CFG_NEAR)
        |=> r_near_plane == $past(i_cfg_data))
        else $error("near plane write lost");

endmodule
